// ===== hdl/spi_master_register_block_macros.svh =====
// Assertion macros for the SPI master register block.
// Every use sees clk_i and rst_ni of the module it stands in.
`ifndef SPI_MASTER_REGISTER_BLOCK_MACROS_SVH
`define SPI_MASTER_REGISTER_BLOCK_MACROS_SVH

`ifndef SYNTHESIS

`define SPI_MRB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spi_mrb assertion failed");

`define SPI_MRB_ASSERT_NEXT(name, ante, cons) \
  `SPI_MRB_ASSERT(name, (ante) |=> (cons))

`else

`define SPI_MRB_ASSERT(name, prop)

`define SPI_MRB_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hdl/spi_mrb_pkg.sv =====
`timescale 1ns / 1ps

package spi_mrb_pkg;

  localparam int unsigned NumSelectsDef = 4;
  localparam int unsigned QueueDepthDef = 8;

  // Item commands
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdXfer  = 2'd2;
  localparam logic [1:0] CmdNop   = 2'd3;

  // Register byte offsets
  localparam logic [6:0] AddrClkDiv  = 7'h00;
  localparam logic [6:0] AddrClkMode = 7'h04;
  localparam logic [6:0] AddrCsId    = 7'h10;
  localparam logic [6:0] AddrCsDef   = 7'h14;
  localparam logic [6:0] AddrCsMode  = 7'h18;
  localparam logic [6:0] AddrDelay0  = 7'h28;
  localparam logic [6:0] AddrDelay1  = 7'h2c;
  localparam logic [6:0] AddrFmt     = 7'h40;
  localparam logic [6:0] AddrTxData  = 7'h48;
  localparam logic [6:0] AddrRxData  = 7'h4c;
  localparam logic [6:0] AddrTxMark  = 7'h50;
  localparam logic [6:0] AddrRxMark  = 7'h54;
  localparam logic [6:0] AddrFCtrl   = 7'h60;
  localparam logic [6:0] AddrFFmt    = 7'h64;
  localparam logic [6:0] AddrIe      = 7'h70;
  localparam logic [6:0] AddrIp      = 7'h74;

  // Chip select modes
  localparam logic [1:0] CsModeAuto = 2'd0;
  localparam logic [1:0] CsModeHold = 2'd2;
  localparam logic [1:0] CsModeOff  = 2'd3;

  // Reset values
  localparam logic [11:0] ClkDivRst  = 12'd3;
  localparam logic [31:0] CsDefRst   = 32'hffff_ffff;
  localparam logic [15:0] Delay0Rst  = 16'h0101;
  localparam logic [15:0] Delay1Rst  = 16'h0001;
  localparam logic [3:0]  FmtLenRst  = 4'h8;
  localparam logic [3:0]  FmtLowRst  = 4'h8;
  localparam logic [31:0] FFmtRst    = 32'h0003_0007;

  localparam logic [31:0] FFmtMask   = 32'hffff_3fff;
  localparam logic [31:0] StatusFlag = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  reg_addr;
    logic [31:0] write_data;
    logic [7:0]  miso_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic [3:0]  chip_selects;
    logic        irq_line;
  } result_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [3:0] count;
    logic [7:0] head;
  } fifo_stat_t;

endpackage

// ===== hdl/spi_mrb_fifo.sv =====
`timescale 1ns / 1ps
`include "spi_master_register_block_macros.svh"

module spi_mrb_fifo #(
  parameter int unsigned Depth = spi_mrb_pkg::QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spi_mrb_pkg::fifo_ctrl_t ctrl_i,
  output spi_mrb_pkg::fifo_stat_t stat_o
);
  import spi_mrb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      head_data_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + PtrW'(1);
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(ctrl_i.push) - CntW'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Register the entry at the next head; a push into that slot bypasses the array
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= ctrl_i.wdata;
    end
    head_data_q <= (ctrl_i.push && (tail_q == head_d)) ? ctrl_i.wdata : mem_q[head_d];
  end

  assign stat_o.count = 4'(cnt_q);
  assign stat_o.head  = head_data_q;

  `SPI_MRB_ASSERT(a_cnt_bound, (cnt_q <= CntW'(Depth)))
  `SPI_MRB_ASSERT(a_no_overflow, (ctrl_i.push |-> (cnt_q != CntW'(Depth))))
  `SPI_MRB_ASSERT(a_no_underflow, (ctrl_i.pop |-> (cnt_q != '0)))

endmodule

// ===== hdl/spi_mrb_core.sv =====
`timescale 1ns / 1ps
`include "spi_master_register_block_macros.svh"

module spi_mrb_core #(
  parameter int unsigned NumSelects = spi_mrb_pkg::NumSelectsDef,
  parameter int unsigned QueueDepth = spi_mrb_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  spi_mrb_pkg::item_t   item_i,
  output spi_mrb_pkg::result_t result_o
);
  import spi_mrb_pkg::*;

  localparam logic [3:0] LineMask = 4'((1 << NumSelects) - 1);
  localparam logic [1:0] IdMask   = 2'((1 << $clog2(NumSelects)) - 1);
  localparam logic [3:0] FullCnt  = 4'(QueueDepth);

  logic [11:0] clk_div_q, clk_div_d;
  logic [1:0]  clk_mode_q, clk_mode_d;
  logic [1:0]  cs_id_q, cs_id_d;
  logic [31:0] cs_def_q, cs_def_d;
  logic [1:0]  cs_mode_q, cs_mode_d;
  logic [15:0] dly0_q, dly0_d, dly1_q, dly1_d;
  logic [3:0]  fmt_len_q, fmt_len_d, fmt_low_q, fmt_low_d;
  logic [2:0]  tx_mark_q, tx_mark_d, rx_mark_q, rx_mark_d;
  logic        fctrl_q, fctrl_d;
  logic [31:0] ffmt_q, ffmt_d;
  logic [1:0]  ie_q, ie_d;
  logic [3:0]  lines_q, lines_d;

  fifo_ctrl_t tx_ctrl, rx_ctrl;
  fifo_stat_t tx_stat, rx_stat;

  logic        is_rd, is_wr, xfer;
  logic        tx_full, rx_full, rx_empty;
  logic [1:0]  ip_now, ip_next;
  logic [3:0]  tx_cnt_d, rx_cnt_d;
  logic [31:0] rdata;
  logic [1:0]  new_id;
  logic [3:0]  base_lines, sel_lines, shift_lines;
  logic [3:0]  len_eff;
  logic [7:0]  len_mask;

  spi_mrb_fifo #(.Depth(QueueDepth)) u_tx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tx_ctrl),
    .stat_o (tx_stat)
  );

  spi_mrb_fifo #(.Depth(QueueDepth)) u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rx_ctrl),
    .stat_o (rx_stat)
  );

  assign is_rd    = (item_i.cmd == CmdRead);
  assign is_wr    = (item_i.cmd == CmdWrite);
  assign xfer     = (item_i.cmd == CmdXfer) && (tx_stat.count != '0);
  assign tx_full  = (tx_stat.count == FullCnt);
  assign rx_full  = (rx_stat.count == FullCnt);
  assign rx_empty = (rx_stat.count == '0);
  assign ip_now   = {rx_stat.count > {1'b0, rx_mark_q}, tx_stat.count < {1'b0, tx_mark_q}};
  assign new_id   = item_i.write_data[1:0] & IdMask;

  // Lines with the selected chip select flipped to its active level
  always_comb begin
    sel_lines = cs_def_q[3:0] & LineMask;
    if ({1'b0, cs_id_q} < 3'(NumSelects)) begin
      sel_lines = (sel_lines ^ (4'd1 << cs_id_q)) & LineMask;
    end
    shift_lines = (cs_mode_q != CsModeOff) ? sel_lines : lines_q;
  end

  always_comb begin
    rdata = '0;
    case (item_i.reg_addr)
      AddrClkDiv:  rdata = {20'd0, clk_div_q};
      AddrClkMode: rdata = {30'd0, clk_mode_q};
      AddrCsId:    rdata = {30'd0, cs_id_q};
      AddrCsDef:   rdata = cs_def_q;
      AddrCsMode:  rdata = {30'd0, cs_mode_q};
      AddrDelay0:  rdata = {8'd0, dly0_q[15:8], 8'd0, dly0_q[7:0]};
      AddrDelay1:  rdata = {8'd0, dly1_q[15:8], 8'd0, dly1_q[7:0]};
      AddrFmt:     rdata = {12'd0, fmt_len_q, 12'd0, fmt_low_q};
      AddrTxData:  rdata = tx_full ? StatusFlag : '0;
      AddrRxData:  rdata = rx_empty ? StatusFlag : {24'd0, rx_stat.head};
      AddrTxMark:  rdata = {29'd0, tx_mark_q};
      AddrRxMark:  rdata = {29'd0, rx_mark_q};
      AddrFCtrl:   rdata = {31'd0, fctrl_q};
      AddrFFmt:    rdata = ffmt_q;
      AddrIe:      rdata = {30'd0, ie_q};
      AddrIp:      rdata = {30'd0, ip_now};
      default:     rdata = '0;
    endcase
  end

  always_comb begin
    clk_div_d  = clk_div_q;
    clk_mode_d = clk_mode_q;
    cs_id_d    = cs_id_q;
    cs_def_d   = cs_def_q;
    cs_mode_d  = cs_mode_q;
    dly0_d     = dly0_q;
    dly1_d     = dly1_q;
    fmt_len_d  = fmt_len_q;
    fmt_low_d  = fmt_low_q;
    tx_mark_d  = tx_mark_q;
    rx_mark_d  = rx_mark_q;
    fctrl_d    = fctrl_q;
    ffmt_d     = ffmt_q;
    ie_d       = ie_q;
    lines_d    = lines_q;
    base_lines = item_i.write_data[3:0] & LineMask;
    if (is_wr) begin
      case (item_i.reg_addr)
        AddrClkDiv:  clk_div_d = item_i.write_data[11:0];
        AddrClkMode: clk_mode_d = item_i.write_data[1:0];
        AddrCsId: begin
          if (({1'b0, new_id} < 3'(NumSelects)) && (new_id != cs_id_q)) begin
            cs_id_d = new_id;
            lines_d = cs_def_q[3:0] & LineMask;
          end
        end
        AddrCsDef: begin
          if (item_i.write_data != cs_def_q) begin
            cs_def_d = item_i.write_data;
            lines_d  = base_lines;
          end
        end
        AddrCsMode: begin
          if (item_i.write_data[1:0] != cs_mode_q) begin
            cs_mode_d = item_i.write_data[1:0];
            lines_d   = cs_def_q[3:0] & LineMask;
          end
        end
        AddrDelay0:  dly0_d = {item_i.write_data[23:16], item_i.write_data[7:0]};
        AddrDelay1:  dly1_d = {item_i.write_data[23:16], item_i.write_data[7:0]};
        AddrFmt: begin
          fmt_len_d = item_i.write_data[19:16];
          fmt_low_d = item_i.write_data[3:0];
        end
        AddrTxMark:  tx_mark_d = item_i.write_data[2:0];
        AddrRxMark:  rx_mark_d = item_i.write_data[2:0];
        AddrFCtrl:   fctrl_d = item_i.write_data[0];
        AddrFFmt:    ffmt_d = item_i.write_data & FFmtMask;
        AddrIe:      ie_d = item_i.write_data[1:0];
        default:     ;
      endcase
    end else if (xfer) begin
      // Auto mode drops the chip select again once the byte is out
      lines_d = (cs_mode_q == CsModeAuto) ? (cs_def_q[3:0] & LineMask) : shift_lines;
    end
  end

  always_comb begin
    tx_ctrl.push  = en_i && is_wr && (item_i.reg_addr == AddrTxData) && !tx_full;
    tx_ctrl.pop   = en_i && xfer;
    tx_ctrl.wdata = item_i.write_data[7:0];
    rx_ctrl.push  = en_i && xfer && !rx_full && !fmt_low_q[3];
    rx_ctrl.pop   = en_i && is_rd && (item_i.reg_addr == AddrRxData) && !rx_empty;
    rx_ctrl.wdata = item_i.miso_byte;
    tx_cnt_d = tx_stat.count + 4'(tx_ctrl.push) - 4'(tx_ctrl.pop);
    rx_cnt_d = rx_stat.count + 4'(rx_ctrl.push) - 4'(rx_ctrl.pop);
    ip_next  = {rx_cnt_d > {1'b0, rx_mark_d}, tx_cnt_d < {1'b0, tx_mark_d}};
  end

  assign len_eff  = (fmt_len_q > 4'd8) ? 4'd8 : fmt_len_q;
  assign len_mask = ~(8'hff << len_eff);

  always_comb begin
    result_o.read_data    = is_rd ? rdata : '0;
    result_o.mosi_valid   = xfer;
    result_o.mosi_byte    = xfer ? (tx_stat.head & len_mask) : '0;
    result_o.chip_selects = xfer ? shift_lines : lines_d;
    result_o.irq_line     = |(ie_d & ip_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_div_q  <= ClkDivRst;
      clk_mode_q <= '0;
      cs_id_q    <= '0;
      cs_def_q   <= CsDefRst;
      cs_mode_q  <= CsModeAuto;
      dly0_q     <= Delay0Rst;
      dly1_q     <= Delay1Rst;
      fmt_len_q  <= FmtLenRst;
      fmt_low_q  <= FmtLowRst;
      tx_mark_q  <= '0;
      rx_mark_q  <= '0;
      fctrl_q    <= 1'b1;
      ffmt_q     <= FFmtRst;
      ie_q       <= '0;
      lines_q    <= CsDefRst[3:0] & LineMask;
    end else if (en_i) begin
      clk_div_q  <= clk_div_d;
      clk_mode_q <= clk_mode_d;
      cs_id_q    <= cs_id_d;
      cs_def_q   <= cs_def_d;
      cs_mode_q  <= cs_mode_d;
      dly0_q     <= dly0_d;
      dly1_q     <= dly1_d;
      fmt_len_q  <= fmt_len_d;
      fmt_low_q  <= fmt_low_d;
      tx_mark_q  <= tx_mark_d;
      rx_mark_q  <= rx_mark_d;
      fctrl_q    <= fctrl_d;
      ffmt_q     <= ffmt_d;
      ie_q       <= ie_d;
      lines_q    <= lines_d;
    end
  end

  `SPI_MRB_ASSERT(a_cs_id_range, ({1'b0, cs_id_q} < 3'(NumSelects)))
  `SPI_MRB_ASSERT(a_lines_masked, ((lines_q & ~LineMask) == 4'd0))
  `SPI_MRB_ASSERT(a_pop_needs_xfer, (tx_ctrl.pop |-> (item_i.cmd == CmdXfer)))
  `SPI_MRB_ASSERT_NEXT(a_auto_release, (en_i && xfer && (cs_mode_q == CsModeAuto)),
    (lines_q == (cs_def_q[3:0] & LineMask)))

endmodule

// ===== hdl/spi_master_register_block.sv =====
`timescale 1ns / 1ps
`include "spi_master_register_block_macros.svh"

// SPI master register block: each transaction on the input channel is a bus read, a bus
// write, one transfer slot or a no-op, and yields exactly one result transaction. The
// block takes one item per clock cycle while the output is not stalled; an item is held
// in an input register, decoded combinationally against the register file and the two
// byte FIFOs, and its result is then written into the result register. The only stall
// comes from the output side: when both the input and the result register are full and
// the result is not taken, input ready drops. No clearing pass is needed after reset.
module spi_master_register_block #(
  parameter int unsigned NumSelects = spi_mrb_pkg::NumSelectsDef,
  parameter int unsigned QueueDepth = spi_mrb_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spi_mrb_pkg::item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spi_mrb_pkg::result_t out_data_o
);
  import spi_mrb_pkg::*;

  item_t   in_q;
  result_t out_q, result;
  logic    in_valid_q, out_valid_q;
  logic    in_valid_d, out_valid_d;
  logic    advance, accept;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  spi_mrb_core #(
    .NumSelects (NumSelects),
    .QueueDepth (QueueDepth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on the handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPI_MRB_ASSERT(a_stall_cause, (!in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i)))
  `SPI_MRB_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
  `SPI_MRB_ASSERT(a_idle_mosi_zero,
    ((out_valid_q && !out_q.mosi_valid) |-> (out_q.mosi_byte == 8'd0)))
  `SPI_MRB_ASSERT(a_xfer_no_rdata, ((out_valid_q && out_q.mosi_valid) |-> (out_q.read_data == '0)))

endmodule
